// ===== design/tabu_move_fifo_lookup_core_defines.svh =====
// Assertion macros shared by the tabu move list RTL.
`ifndef TABU_MOVE_FIFO_LOOKUP_CORE_DEFINES_SVH
`define TABU_MOVE_FIFO_LOOKUP_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define TMFL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TMFL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define TMFL_ASSERT(lbl, clk, rst_n, prop, msg)
`define TMFL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== design/tmfl_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and helpers for the tabu move list.
package tmfl_pkg;

    localparam int unsigned MAX_ENTRIES_DEF  = 64;
    localparam int unsigned NODE_COUNT_DEF   = 1024;
    localparam int unsigned TENURE_W         = 7;
    localparam int unsigned REQ_W            = 2;
    localparam int unsigned DATA_W           = 32;
    localparam int unsigned ADDR_W           = 3;
    localparam logic [TENURE_W-1:0] START_TENURE_RST = 7'd8;
    localparam logic [0:0] REG_START_TENURE  = 1'b0;

    typedef enum logic [REQ_W-1:0] {
        REQ_CHECK  = 2'd0,
        REQ_ADD    = 2'd1,
        REQ_RESIZE = 2'd2,
        REQ_CLEAR  = 2'd3
    } tmfl_req_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } tmfl_state_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } tmfl_cmd_t;

    function automatic int unsigned clamp_tenure(input logic [TENURE_W-1:0] t,
                                                 input int unsigned max_entries);
        int unsigned v;
        v = int'(t);
        if (v < 1) begin
            return 1;
        end
        if (v > max_entries) begin
            return max_entries;
        end
        return v;
    endfunction

endpackage

// ===== design/tmfl_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: request capture, execute sequencing and result beat valid.
`include "tabu_move_fifo_lookup_core_defines.svh"
module tmfl_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output tmfl_pkg::tmfl_cmd_t cmd
);

    tmfl_pkg::tmfl_state_t state_reg, state_next;
    logic                  m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tmfl_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tmfl_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = tmfl_pkg::S_EXEC;
                end
            end
            tmfl_pkg::S_EXEC: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = tmfl_pkg::S_IDLE;
                end
            end
            default: state_next = tmfl_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        unique case (state_reg)
            tmfl_pkg::S_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            tmfl_pkg::S_EXEC: begin
                cmd.execute = !m_valid_reg || m_ready;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
        if (cmd.execute) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

    `TMFL_ASSERT(a_capture_idle, aclk, aresetn, !cmd.capture || state_reg == tmfl_pkg::S_IDLE, "capture outside idle")
    `TMFL_ASSERT_NEXT(a_exec_shows, aclk, aresetn, cmd.execute, m_valid_reg, "executed beat not shown")
    `TMFL_ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid_reg && !m_ready, m_valid_reg, "result beat dropped")

endmodule

// ===== design/tmfl_dpath.sv =====
`timescale 1ns / 1ps
// Datapath: request registers, shifting entry cells with comparators, count and tenure.
`include "tabu_move_fifo_lookup_core_defines.svh"
module tmfl_dpath #(
    parameter int unsigned MAX_ENTRIES = tmfl_pkg::MAX_ENTRIES_DEF,
    parameter int unsigned NODE_COUNT  = tmfl_pkg::NODE_COUNT_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  tmfl_pkg::tmfl_cmd_t               cmd,
    input  logic [tmfl_pkg::REQ_W-1:0]        s_req_type,
    input  logic [$clog2(NODE_COUNT)-1:0]     s_first_node,
    input  logic [$clog2(NODE_COUNT)-1:0]     s_second_node,
    input  logic [tmfl_pkg::TENURE_W-1:0]     s_req_tenure,
    input  logic [tmfl_pkg::TENURE_W-1:0]     start_tenure,
    output logic                              m_is_tabu,
    output logic [tmfl_pkg::TENURE_W-1:0]     m_entry_count,
    output logic [tmfl_pkg::TENURE_W-1:0]     m_tenure_now
);

    localparam int unsigned NODE_W = $clog2(NODE_COUNT);
    localparam int unsigned PAIR_W = 2 * NODE_W;
    localparam int unsigned CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CAP_RST =
        CNT_W'(tmfl_pkg::clamp_tenure(tmfl_pkg::START_TENURE_RST, MAX_ENTRIES));

    tmfl_pkg::tmfl_req_t               req_reg;
    logic [PAIR_W-1:0]                 pair_reg;
    logic [tmfl_pkg::TENURE_W-1:0]     want_reg;
    logic [PAIR_W-1:0]                 entry_reg [MAX_ENTRIES];
    logic [CNT_W-1:0]                  fill_reg, fill_next;
    logic [CNT_W-1:0]                  cap_reg, cap_next;
    logic [MAX_ENTRIES-1:0]            match_vec;
    logic                              full;
    logic                              add_now;
    logic                              is_tabu_reg;
    logic [tmfl_pkg::TENURE_W-1:0]     count_reg;
    logic [tmfl_pkg::TENURE_W-1:0]     tenure_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg  <= tmfl_pkg::tmfl_req_t'(s_req_type);
            pair_reg <= (s_first_node < s_second_node) ? {s_first_node, s_second_node}
                                                       : {s_second_node, s_first_node};
            want_reg <= s_req_tenure;
        end
    end

    assign full    = fill_reg == cap_reg;
    assign add_now = cmd.execute && req_reg == tmfl_pkg::REQ_ADD;

    for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
        assign match_vec[k] = (entry_reg[k] == pair_reg) && (CNT_W'(k) < fill_reg);
        if (k + 1 < MAX_ENTRIES) begin : g_shift
            always_ff @(posedge aclk) begin
                if (add_now) begin
                    if (full) begin
                        if (CNT_W'(k + 1) < cap_reg) begin
                            entry_reg[k] <= entry_reg[k + 1];
                        end else if (CNT_W'(k + 1) == cap_reg) begin
                            entry_reg[k] <= pair_reg;
                        end
                    end else if (fill_reg == CNT_W'(k)) begin
                        entry_reg[k] <= pair_reg;
                    end
                end
            end
        end else begin : g_last
            always_ff @(posedge aclk) begin
                if (add_now) begin
                    if (full) begin
                        if (CNT_W'(k + 1) == cap_reg) begin
                            entry_reg[k] <= pair_reg;
                        end
                    end else if (fill_reg == CNT_W'(k)) begin
                        entry_reg[k] <= pair_reg;
                    end
                end
            end
        end
    end

    always_comb begin
        fill_next = fill_reg;
        cap_next  = cap_reg;
        unique case (req_reg)
            tmfl_pkg::REQ_CHECK: begin
                fill_next = fill_reg;
            end
            tmfl_pkg::REQ_ADD: begin
                if (!full) begin
                    fill_next = fill_reg + CNT_W'(1);
                end
            end
            tmfl_pkg::REQ_RESIZE: begin
                cap_next  = CNT_W'(tmfl_pkg::clamp_tenure(want_reg, MAX_ENTRIES));
                fill_next = (fill_reg > cap_next) ? cap_next : fill_reg;
            end
            tmfl_pkg::REQ_CLEAR: begin
                fill_next = '0;
                cap_next  = CNT_W'(tmfl_pkg::clamp_tenure(start_tenure, MAX_ENTRIES));
            end
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            cap_reg  <= CAP_RST;
        end else if (cmd.execute) begin
            fill_reg <= fill_next;
            cap_reg  <= cap_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.execute) begin
            is_tabu_reg <= (req_reg == tmfl_pkg::REQ_CHECK) && (|match_vec);
            count_reg   <= tmfl_pkg::TENURE_W'(fill_next);
            tenure_reg  <= tmfl_pkg::TENURE_W'(cap_next);
        end
    end

    assign m_is_tabu     = is_tabu_reg;
    assign m_entry_count = count_reg;
    assign m_tenure_now  = tenure_reg;

    `TMFL_ASSERT(a_fill_in_cap, aclk, aresetn, fill_reg <= cap_reg, "fill count above tenure")
    `TMFL_ASSERT(a_cap_range, aclk, aresetn, cap_reg != '0 && cap_reg <= CNT_W'(MAX_ENTRIES), "tenure out of range")
    `TMFL_ASSERT_NEXT(a_clear_empties, aclk, aresetn, cmd.execute && req_reg == tmfl_pkg::REQ_CLEAR, fill_reg == '0, "clear left entries")

endmodule

// ===== design/tabu_move_fifo_lookup_core.sv =====
`timescale 1ns / 1ps
// Top level of the tabu move list: configuration register, controller and datapath.
//  channel   | handshake              | payload
//  s_ (req)  | s_valid / s_ready      | req_type, first_node, second_node, req_tenure
//  m_ (res)  | m_valid / m_ready      | is_tabu, entry_count, tenure_now
//  apb (cfg) | psel, penable, pready  | paddr, pwrite, pwdata, prdata
// A request beat is captured in the idle state, then compared and applied to the cells in execute.
// The execute cycle waits while an earlier result beat is still not taken by m_ready.
// Every entry cell has its own comparator, so the check and shift finish within the execute step.
// aresetn (synchronous) empties the list and loads the reset tenure; no clearing pass.
module tabu_move_fifo_lookup_core #(
    parameter int unsigned MAX_ENTRIES = tmfl_pkg::MAX_ENTRIES_DEF,
    parameter int unsigned NODE_COUNT  = tmfl_pkg::NODE_COUNT_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [tmfl_pkg::REQ_W-1:0]        s_req_type,
    input  logic [$clog2(NODE_COUNT)-1:0]     s_first_node,
    input  logic [$clog2(NODE_COUNT)-1:0]     s_second_node,
    input  logic [tmfl_pkg::TENURE_W-1:0]     s_req_tenure,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_is_tabu,
    output logic [tmfl_pkg::TENURE_W-1:0]     m_entry_count,
    output logic [tmfl_pkg::TENURE_W-1:0]     m_tenure_now,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tmfl_pkg::ADDR_W-1:0]       paddr,
    input  logic [tmfl_pkg::DATA_W-1:0]       pwdata,
    output logic [tmfl_pkg::DATA_W-1:0]       prdata,
    output logic                              pready
);

    tmfl_pkg::tmfl_cmd_t              cmd;
    logic [tmfl_pkg::TENURE_W-1:0]    start_tenure_reg;
    logic                             sel_start;

    assign pready    = 1'b1;
    assign sel_start = paddr[tmfl_pkg::ADDR_W-1:2] == tmfl_pkg::REG_START_TENURE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_tenure_reg <= tmfl_pkg::START_TENURE_RST;
        end else if (psel && penable && pwrite && sel_start) begin
            start_tenure_reg <= pwdata[tmfl_pkg::TENURE_W-1:0];
        end
    end

    assign prdata = sel_start ? tmfl_pkg::DATA_W'(start_tenure_reg) : '0;

    tmfl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    tmfl_dpath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .NODE_COUNT  (NODE_COUNT)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .s_req_type    (s_req_type),
        .s_first_node  (s_first_node),
        .s_second_node (s_second_node),
        .s_req_tenure  (s_req_tenure),
        .start_tenure  (start_tenure_reg),
        .m_is_tabu     (m_is_tabu),
        .m_entry_count (m_entry_count),
        .m_tenure_now  (m_tenure_now)
    );

endmodule
